// ===== src/brf_pkg.sv =====
package brf_pkg;

  // ring geometry
  localparam int CAPACITY  = 1024;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = IDX_W + 1;
  localparam int SUM_W     = CNT_W + 1;

  // replacement message
  localparam int MSG_LEN   = 38;
  localparam int MSG_IDX_W = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1;

  // trigger pattern, oldest byte first: pat_first, pat_mid, pat_last
  localparam logic [7:0] PAT_FIRST = 8'h55;
  localparam logic [7:0] PAT_MID   = 8'h43;
  localparam logic [7:0] PAT_LAST  = 8'h46;

  // message bytes written in place of the pattern
  localparam logic [7:0] MSG_ROM [MSG_LEN] = '{
    8'h55, 8'h6E, 8'h64, 8'h65, 8'h66, 8'h65, 8'h61, 8'h74, 8'h65, 8'h64,
    8'h20, 8'h32, 8'h30, 8'h31, 8'h38,
    8'h20, 8'h4E, 8'h61, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h61, 8'h6C,
    8'h20, 8'h43, 8'h68, 8'h61, 8'h6D, 8'h70, 8'h69, 8'h6F, 8'h6E, 8'h73,
    8'h20, 8'h55, 8'h43, 8'h46
  };

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_SPAN  = 2'd2,
    OP_CLEAR = 2'd3
  } brf_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DROP_FULL = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_SPAN_LONG = 2'd3
  } brf_status_t;

  typedef struct packed {
    brf_op_t          operation;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] span_length;
  } brf_in_t;

  typedef struct packed {
    logic [7:0]       read_byte;
    logic [IDX_W-1:0] first_offset;
    logic [CNT_W-1:0] first_length;
    logic [CNT_W-1:0] second_length;
    logic [CNT_W-1:0] fill_count;
    logic             is_empty;
    logic             is_full;
    brf_status_t      status;
    logic             replaced;
  } brf_out_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic push_wr;
    logic set_full;
    logic rd_third;
    logic rewind;
    logic msg_wr;
    logic pop_rd;
    logic set_empty;
    logic pop_cap;
    logic span;
    logic clear;
    logic load_out;
  } brf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic msg_stop;
    logic msg_last;
    logic out_free;
  } brf_sts_t;

endpackage

// ===== src/byte_ring_fifo_with_pattern_replace.sv =====
// Byte ring fifo of CAPACITY bytes with pattern replacement.
// Input channel (in_valid/in_ready/in_data) carries one item per operation:
// push, pop, take span or clear. Each item gives exactly one result item on
// the output channel (out_valid/out_ready/out_data) with the popped byte, the
// span segments, the fill level, flags and a status code.
// The block works on one item at a time; in_ready is high only while idle.
// Per item, with the receiver ready: a push writes the byte and checks the
//   trigger pattern, or drops the byte when the ring is full; a push that
//   completes the trigger pattern then writes the message over it, stopping
//   early when the ring fills; a pop reads the byte unless the ring is empty;
//   take span and clear update the indices directly.
// The push cost is set by the single read port of the byte store: the two
// older bytes of the pattern are read in turn, then the message is written
// one byte per cycle. The result reaches out_valid in the same cycle that
// in_ready rises again.
// Reset (rst_n low, synchronous) empties the ring with both indices at zero
// and drops any pending result; store contents are not cleared.
// When the receiver stalls, the result is held in the output register and the
// block finishes the next item's work, then waits before loading its result.
module byte_ring_fifo_with_pattern_replace import brf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  brf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output brf_out_t out_data
);

  brf_cmd_t cmd;
  brf_sts_t sts;

  // sequencer
  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // ring store, indices and result register
  brf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== src/brf_ctrl.sv =====
module brf_ctrl import brf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  brf_op_t  in_op,
  input  brf_sts_t sts,
  output logic     in_ready,
  output brf_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_RD2,
    S_CHK,
    S_MSG,
    S_POP,
    S_POPW,
    S_SPAN,
    S_CLR,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          unique case (in_op)
            OP_PUSH:  state_nxt = S_PUSH;
            OP_POP:   state_nxt = S_POP;
            OP_SPAN:  state_nxt = S_SPAN;
            OP_CLEAR: state_nxt = S_CLR;
            default:  state_nxt = S_CLR;
          endcase
        end
      end
      S_PUSH: begin
        if (sts.full) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.push_wr = 1'b1;
          state_nxt   = S_RD2;
        end
      end
      S_RD2: begin
        cmd.rd_third = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        if (sts.hit) begin
          cmd.rewind = 1'b1;
          state_nxt  = S_MSG;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MSG: begin
        if (sts.msg_stop) begin
          state_nxt = S_DONE;
        end else begin
          cmd.msg_wr = 1'b1;
          if (sts.msg_last) state_nxt = S_DONE;
        end
      end
      S_POP: begin
        if (sts.empty) begin
          cmd.set_empty = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POPW;
        end
      end
      S_POPW: begin
        cmd.pop_cap = 1'b1;
        state_nxt   = S_DONE;
      end
      S_SPAN: begin
        cmd.span  = 1'b1;
        state_nxt = S_DONE;
      end
      S_CLR: begin
        cmd.clear = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/brf_dp.sv =====
module brf_dp import brf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  brf_in_t  in_data,
  input  brf_cmd_t cmd,
  input  logic     out_ready,
  output brf_sts_t sts,
  output logic     out_valid,
  output brf_out_t out_data
);

  // item and ring state
  brf_in_t              item_r;
  logic [IDX_W-1:0]     wi_r, ri_r;
  logic                 empty_r;

  // byte store
  logic [7:0]           mem [CAPACITY];
  logic [7:0]           rdata_r;
  logic [IDX_W-1:0]     raddr;
  logic [7:0]           wdata;
  logic                 we;

  // pattern check and message walk
  logic                 c_match_r;
  logic [MSG_IDX_W-1:0] msg_idx_r;

  // result fields
  logic [7:0]           rbyte_r;
  logic [IDX_W-1:0]     off_r;
  logic [CNT_W-1:0]     len1_r, len2_r;
  brf_status_t          status_r;
  logic                 repl_r;

  // output register
  brf_out_t             out_r;
  logic                 out_valid_r;

  // derived ring status
  logic [IDX_W-1:0]     diff;
  logic [CNT_W-1:0]     cnt;
  logic                 full;
  logic [SUM_W-1:0]     span_sum;
  logic                 span_wraps;
  logic                 span_ok;
  logic [IDX_W-1:0]     ri_span;
  logic                 out_free;

  assign diff       = wi_r - ri_r;
  assign cnt        = (diff != '0) ? {1'b0, diff} :
                      (empty_r ? '0 : CNT_W'(CAPACITY));
  assign full       = !empty_r && (wi_r == ri_r);
  assign span_sum   = SUM_W'(ri_r) + SUM_W'(item_r.span_length);
  assign span_wraps = span_sum > SUM_W'(CAPACITY);
  assign span_ok    = (item_r.span_length != '0) && (item_r.span_length <= cnt);
  assign ri_span    = span_sum[IDX_W-1:0];
  assign out_free   = !out_valid_r || out_ready;

  // status to controller
  always_comb begin
    sts.full     = full;
    sts.empty    = empty_r;
    sts.hit      = (item_r.data_byte == PAT_LAST) && c_match_r &&
                   (rdata_r == PAT_FIRST) && (cnt >= CNT_W'(3));
    sts.msg_stop = (msg_idx_r != '0) && full;
    sts.msg_last = (msg_idx_r == MSG_IDX_W'(MSG_LEN - 1));
    sts.out_free = out_free;
  end

  // store port selection
  always_comb begin
    we    = cmd.push_wr || cmd.msg_wr;
    wdata = cmd.msg_wr ? MSG_ROM[msg_idx_r] : item_r.data_byte;
    if (cmd.push_wr) begin
      raddr = wi_r - IDX_W'(1);
    end else if (cmd.rd_third) begin
      raddr = wi_r - IDX_W'(3);
    end else begin
      raddr = ri_r;
    end
  end

  // byte store, registered read
  always_ff @(posedge clk) begin
    if (we) mem[wi_r] <= wdata;
    rdata_r <= mem[raddr];
  end

  // ring indices, empty flag, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r        <= '0;
      ri_r        <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        wi_r    <= '0;
        ri_r    <= '0;
        empty_r <= 1'b1;
      end
      if (cmd.push_wr || cmd.msg_wr) begin
        wi_r    <= wi_r + IDX_W'(1);
        empty_r <= 1'b0;
      end
      if (cmd.rewind) wi_r <= wi_r - IDX_W'(3);
      if (cmd.pop_rd) begin
        ri_r    <= ri_r + IDX_W'(1);
        empty_r <= ((ri_r + IDX_W'(1)) == wi_r);
      end
      if (cmd.span && span_ok) begin
        ri_r    <= ri_span;
        empty_r <= (ri_span == wi_r);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item, result fields and output payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_r   <= in_data;
      rbyte_r  <= '0;
      off_r    <= '0;
      len1_r   <= '0;
      len2_r   <= '0;
      status_r <= ST_OK;
      repl_r   <= 1'b0;
    end
    if (cmd.set_full)  status_r <= ST_DROP_FULL;
    if (cmd.set_empty) status_r <= ST_POP_EMPTY;
    if (cmd.rd_third)  c_match_r <= (rdata_r == PAT_MID);
    if (cmd.rewind) begin
      repl_r    <= 1'b1;
      msg_idx_r <= '0;
    end
    if (cmd.msg_wr)  msg_idx_r <= msg_idx_r + MSG_IDX_W'(1);
    if (cmd.pop_cap) rbyte_r <= rdata_r;
    if (cmd.span && (item_r.span_length != '0)) begin
      if (!span_ok) begin
        status_r <= ST_SPAN_LONG;
      end else begin
        off_r <= ri_r;
        if (span_wraps) begin
          len1_r <= CNT_W'(CAPACITY) - {1'b0, ri_r};
          len2_r <= CNT_W'(span_sum - SUM_W'(CAPACITY));
        end else begin
          len1_r <= item_r.span_length;
        end
      end
    end
    if (cmd.load_out) begin
      out_r.read_byte     <= rbyte_r;
      out_r.first_offset  <= off_r;
      out_r.first_length  <= len1_r;
      out_r.second_length <= len2_r;
      out_r.fill_count    <= cnt;
      out_r.is_empty      <= empty_r;
      out_r.is_full       <= full;
      out_r.status        <= status_r;
      out_r.replaced      <= repl_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // an empty ring always has matching indices
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (wi_r == ri_r))
    else $error("empty flag set with differing indices");

  // a pushed byte is never written into a full ring
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> !full)
    else $error("push write while ring full");

  // a result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // clear leaves an empty ring at index zero
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (empty_r && (wi_r == '0) && (ri_r == '0)))
    else $error("clear did not reset the ring");

endmodule

// ===== bench/tb_byte_ring_fifo_with_pattern_replace.sv =====
module tb_byte_ring_fifo_with_pattern_replace;
  import brf_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 450;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  brf_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  brf_out_t out_data;

  byte_ring_fifo_with_pattern_replace i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // shadow copy of the ring
  bit [7:0]    shadow_mem [CAPACITY];
  int unsigned wr_ptr     = 0;
  int unsigned rd_ptr     = 0;
  bit          ring_empty = 1'b1;

  brf_out_t awaited_replies [$];
  int       mismatch_count = 0;
  int       idle_cycles    = 0;
  int       burst_left     = 0;
  int       hold_orders    = 0;
  int       hold_served    = 0;
  int       hold_left      = 0;
  int       sink_cycle     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ring bookkeeping
  function automatic int unsigned ring_fill();
    if (wr_ptr > rd_ptr) return wr_ptr - rd_ptr;
    if (rd_ptr > wr_ptr) return CAPACITY - rd_ptr + wr_ptr;
    return ring_empty ? 0 : CAPACITY;
  endfunction

  function automatic bit ring_is_full();
    return !ring_empty && wr_ptr == rd_ptr;
  endfunction

  function automatic void ring_put(bit [7:0] b);
    shadow_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % CAPACITY;
    ring_empty = 1'b0;
  endfunction

  // next reply of the ring for one operation, updating the shadow state
  function automatic brf_out_t apply_ring_op(brf_in_t item);
    brf_out_t    r;
    bit          hit;
    bit [7:0]    want_b;
    int unsigned pos;
    int unsigned n;
    r = '0;
    case (item.operation)
      OP_PUSH: begin
        if (ring_is_full()) begin
          r.status = ST_DROP_FULL;
        end else begin
          ring_put(item.data_byte);
          hit = 1'b1;
          // newest byte first; the two newer ones must not sit at the read index
          for (int i = 1; i <= 3; i++) begin
            pos = (wr_ptr + CAPACITY - i) % CAPACITY;
            case (i)
              1: want_b = PAT_LAST;
              2: want_b = PAT_MID;
              default: want_b = PAT_FIRST;
            endcase
            if ((pos == rd_ptr && i != 3) || shadow_mem[pos] != want_b) begin
              hit = 1'b0;
              break;
            end
          end
          if (hit) begin
            r.replaced = 1'b1;
            wr_ptr = (wr_ptr + CAPACITY - 3) % CAPACITY;
            // first message byte always lands, the rest stop at full
            for (int i = 0; i < MSG_LEN; i++) begin
              if (i != 0 && ring_is_full()) break;
              ring_put(MSG_ROM[i]);
            end
          end
        end
      end
      OP_POP: begin
        if (ring_empty) begin
          r.status = ST_POP_EMPTY;
        end else begin
          r.read_byte = shadow_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % CAPACITY;
          if (rd_ptr == wr_ptr) ring_empty = 1'b1;
        end
      end
      OP_SPAN: begin
        n = item.span_length;
        if (n != 0) begin
          if (n > ring_fill()) begin
            r.status = ST_SPAN_LONG;
          end else begin
            r.first_offset = IDX_W'(rd_ptr);
            if (rd_ptr + n > CAPACITY) begin
              r.first_length = CNT_W'(CAPACITY - rd_ptr);
              rd_ptr = (rd_ptr + n) % CAPACITY;
              r.second_length = CNT_W'(rd_ptr);
            end else begin
              r.first_length = CNT_W'(n);
              rd_ptr = (rd_ptr + n) % CAPACITY;
            end
            if (rd_ptr == wr_ptr) ring_empty = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        foreach (shadow_mem[k]) shadow_mem[k] = '0;
        wr_ptr = 0;
        rd_ptr = 0;
        ring_empty = 1'b1;
      end
    endcase
    r.fill_count = CNT_W'(ring_fill());
    r.is_empty   = ring_empty;
    r.is_full    = ring_is_full();
    return r;
  endfunction

  function automatic string reply_str(brf_out_t r);
    return $sformatf(
      "byte=%02h off=%0d len1=%0d len2=%0d fill=%0d empty=%b full=%b st=%0d repl=%b",
      r.read_byte, r.first_offset, r.first_length, r.second_length,
      r.fill_count, r.is_empty, r.is_full, r.status, r.replaced);
  endfunction

  function automatic brf_in_t make_item(brf_op_t op, logic [7:0] b, logic [CNT_W-1:0] n);
    brf_in_t it;
    it.operation   = op;
    it.data_byte   = b;
    it.span_length = n;
    return it;
  endfunction

  // offer one item in bursts with random gaps, predict its reply on accept
  task automatic send_item(brf_in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(30, 80))
                                               : int'($urandom_range(1, 12));
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_replies.push_back(apply_ring_op(item));
  endtask

  // unused fields carry noise
  task automatic push_byte(logic [7:0] b);
    send_item(make_item(OP_PUSH, b, CNT_W'($urandom)));
  endtask

  task automatic pop_byte();
    send_item(make_item(OP_POP, 8'($urandom), CNT_W'($urandom)));
  endtask

  task automatic take_span(logic [CNT_W-1:0] n);
    send_item(make_item(OP_SPAN, 8'($urandom), n));
  endtask

  task automatic clear_ring();
    send_item(make_item(OP_CLEAR, 8'($urandom), CNT_W'($urandom)));
  endtask

  // repeated trigger sequences grow the ring by a message each time
  task automatic fill_with_pattern();
    int unsigned k;
    k = 0;
    while (!ring_is_full()) begin
      case (k % 3)
        0: push_byte(PAT_FIRST);
        1: push_byte(PAT_MID);
        default: push_byte(PAT_LAST);
      endcase
      k++;
    end
  endtask

  // one random operation or short sequence, returns items sent
  task automatic random_op(output int unsigned n_items);
    int unsigned pick;
    int unsigned fill;
    int unsigned len;
    pick = $urandom_range(0, 99);
    fill = ring_fill();
    n_items = 1;
    if (pick < 12) begin
      push_byte(PAT_FIRST);
      push_byte(PAT_MID);
      push_byte(PAT_LAST);
      n_items = 3;
    end else if (pick < 16) begin
      // broken sequence, last byte random
      push_byte(PAT_FIRST);
      push_byte(PAT_MID);
      push_byte(8'($urandom));
      n_items = 3;
    end else if (pick < 45) begin
      push_byte(8'($urandom));
    end else if (pick < 62) begin
      pop_byte();
    end else if (pick < 98) begin
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = $urandom_range(fill + 1, 2047);
        2: len = $urandom_range(0, 2047);
        3: len = fill;
        4, 5, 6: len = (fill == 0) ? 1 : $urandom_range(1, (fill < 40) ? fill : 40);
        default: len = (fill == 0) ? 1 : $urandom_range(1, fill);
      endcase
      take_span(CNT_W'(len));
    end else begin
      clear_ring();
    end
  endtask

  // operations on an empty ring and field extremes
  task automatic test_empty_ring();
    pop_byte();
    take_span('0);
    take_span(CNT_W'(1));
    take_span('1);
    push_byte(8'hff);
    push_byte(8'h00);
    take_span(CNT_W'(2));
    pop_byte();
    clear_ring();
  endtask

  // trigger sequence corner cases
  task automatic test_pattern_cases();
    // two bytes only, match stops at the read index
    push_byte(PAT_MID);
    push_byte(PAT_LAST);
    pop_byte();
    pop_byte();
    // exactly three held, message starts over the oldest byte
    push_byte(PAT_FIRST);
    push_byte(PAT_MID);
    push_byte(PAT_LAST);
    pop_byte();
    take_span(CNT_W'(MSG_LEN - 1));
    // message behind a leading byte
    push_byte(8'h41);
    push_byte(PAT_FIRST);
    push_byte(PAT_MID);
    push_byte(PAT_LAST);
    // broken sequence
    push_byte(PAT_FIRST);
    push_byte(PAT_MID);
    push_byte(8'h47);
    clear_ring();
  endtask

  // full ring, dropped push, split spans and read index wrap
  task automatic test_fill_and_wrap();
    clear_ring();
    repeat (10) push_byte(8'($urandom));
    take_span(CNT_W'(10));
    fill_with_pattern();
    push_byte(8'h5a);
    take_span(CNT_W'(CAPACITY + 1));
    take_span(CNT_W'(CAPACITY));
    fill_with_pattern();
    take_span(CNT_W'(CAPACITY - 10));
    while (!ring_empty) pop_byte();
  endtask

  // receiver holds off while items keep coming
  task automatic test_long_stall();
    int unsigned n;
    int unsigned sent;
    sent = 0;
    hold_orders++;
    while (sent < 40) begin
      random_op(n);
      sent += n;
    end
  endtask

  task automatic test_random_traffic();
    int unsigned n;
    int unsigned sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_op(n);
      sent += n;
    end
  endtask

  // result check against the oldest prediction
  always @(posedge clk) begin : result_check
    brf_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item: %s", reply_str(out_data));
      end else begin
        want = awaited_replies.pop_front();
        if (out_data.read_byte !== want.read_byte ||
            out_data.first_offset !== want.first_offset ||
            out_data.first_length !== want.first_length ||
            out_data.second_length !== want.second_length ||
            out_data.fill_count !== want.fill_count ||
            out_data.is_empty !== want.is_empty ||
            out_data.is_full !== want.is_full ||
            out_data.status !== want.status ||
            out_data.replaced !== want.replaced) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch\n  expected %s\n  actual   %s",
                     reply_str(want), reply_str(out_data));
        end
      end
    end
  end

  // receiver stall pattern, with a long hold on request
  always @(posedge clk) begin : sink_ready
    sink_cycle++;
    if (hold_orders != hold_served) begin
      hold_served = hold_orders;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case ((sink_cycle / 97) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (sink_cycle % 3 == 0);
        default: out_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // no progress on either channel for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : run
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_ring();
    test_pattern_cases();
    test_fill_and_wrap();
    test_long_stall();
    test_random_traffic();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== byte_ring_fifo_with_pattern_replace.f =====
src/brf_pkg.sv
src/brf_ctrl.sv
src/brf_dp.sv
src/byte_ring_fifo_with_pattern_replace.sv
bench/tb_byte_ring_fifo_with_pattern_replace.sv
